[hw/rtl/frt_pkg.sv]
// Shared types and status codes for the fragment reassembly tracker.
`default_nettype none
package frt_pkg;
    localparam logic [2:0] ST_ACCEPTED    = 3'd0;
    localparam logic [2:0] ST_COMPLETE    = 3'd1;
    localparam logic [2:0] ST_BAD_RANGE   = 3'd2;
    localparam logic [2:0] ST_OVERLAP     = 3'd3;
    localparam logic [2:0] ST_TABLE_FULL  = 3'd4;
    localparam logic [2:0] ST_RANGES_FULL = 3'd5;
    localparam logic [2:0] ST_ZERO_SIZE   = 3'd6;

    // Fragment descriptor after classification by the front end.
    typedef struct packed {
        logic [15:0] frame_id;
        logic [15:0] frame_total_size;
        logic [15:0] frag_start;
        logic [15:0] frag_length;
        logic [16:0] frag_end;
        logic        len_zero;
    } t_item;
endpackage
`default_nettype wire

[hw/rtl/fragment_reassembly_tracker_top.sv]
// The back end works on one fragment at a time and takes the next from the queue only when idle;
//   the single read port of the range memory lets it scan one stored range per cycle.
// The front queue holds two fragments, so input is taken while the back end is busy.
// Reset (synchronous, active low) empties the queue, frees every table entry and drops
//   the result register; range and entry contents are not cleared.
`default_nettype none
module fragment_reassembly_tracker_top #(
    parameter int PENDING_FRAMES   = 8,
    parameter int RANGES_PER_FRAME = 16
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire logic [15:0] i_frame_id,
    input  wire logic [15:0] i_frame_total_size,
    input  wire logic [15:0] i_frag_offset,
    input  wire logic [15:0] i_frag_length,
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output logic [2:0]       o_status,
    output logic [15:0]      o_done_frame_id,
    output logic [15:0]      o_done_frame_size
);
    // Queue between front and back end
    logic           q_valid;
    logic           q_pop;
    frt_pkg::t_item q_item;

    // Front: takes each transaction, precomputes fragment end and zero-length flag
    frt_front u_front (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_in_valid         (i_in_valid),
        .o_in_stall         (o_in_stall),
        .i_frame_id         (i_frame_id),
        .i_frame_total_size (i_frame_total_size),
        .i_frag_offset      (i_frag_offset),
        .i_frag_length      (i_frag_length),
        .o_q_valid          (q_valid),
        .o_q_item           (q_item),
        .i_q_pop            (q_pop)
    );

    // Back: lookup, overlap scan, table update, result register
    frt_back #(
        .PENDING_FRAMES   (PENDING_FRAMES),
        .RANGES_PER_FRAME (RANGES_PER_FRAME)
    ) u_back (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_q_valid         (q_valid),
        .i_q_item          (q_item),
        .o_q_pop           (q_pop),
        .o_out_valid       (o_out_valid),
        .i_out_stall       (i_out_stall),
        .o_status          (o_status),
        .o_done_frame_id   (o_done_frame_id),
        .o_done_frame_size (o_done_frame_size)
    );
endmodule
`default_nettype wire

[hw/rtl/frt_front.sv]
// Front end: accepts fragment transactions, classifies them, two-entry queue to the back end.
`default_nettype none
module frt_front (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    output logic               o_in_stall,
    input  wire logic [15:0]   i_frame_id,
    input  wire logic [15:0]   i_frame_total_size,
    input  wire logic [15:0]   i_frag_offset,
    input  wire logic [15:0]   i_frag_length,
    output logic               o_q_valid,
    output frt_pkg::t_item     o_q_item,
    input  wire logic          i_q_pop
);
    frt_pkg::t_item r_slot [2];
    logic           r_wp, r_rp;
    logic [1:0]     r_cnt;
    frt_pkg::t_item n_item;
    logic           push, pop;

    always_comb begin
        n_item.frame_id         = i_frame_id;
        n_item.frame_total_size = i_frame_total_size;
        n_item.frag_start       = i_frag_offset;
        n_item.frag_length      = i_frag_length;
        n_item.frag_end         = {1'b0, i_frag_offset} + {1'b0, i_frag_length};
        n_item.len_zero         = (i_frag_length == 16'd0);
    end

    assign o_in_stall = (r_cnt == 2'd2);
    assign push       = i_in_valid && !o_in_stall;
    assign o_q_valid  = (r_cnt != 2'd0);
    assign pop        = i_q_pop && o_q_valid;
    assign o_q_item   = r_slot[r_rp];

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_slot[r_wp] <= n_item;
        end
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) r_wp <= !r_wp;
            if (pop)  r_rp <= !r_rp;
            r_cnt <= r_cnt + {1'b0, push} - {1'b0, pop};
        end
    end
endmodule
`default_nettype wire

[hw/rtl/frt_back.sv]
// Back end: frame table lookup, range scan over the range memory, update and result register.
`default_nettype none
module frt_back #(
    parameter int PENDING_FRAMES   = 8,
    parameter int RANGES_PER_FRAME = 16
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_q_valid,
    input  wire frt_pkg::t_item i_q_item,
    output logic               o_q_pop,
    output logic               o_out_valid,
    input  wire logic          i_out_stall,
    output logic [2:0]         o_status,
    output logic [15:0]        o_done_frame_id,
    output logic [15:0]        o_done_frame_size
);
    localparam int EW    = (PENDING_FRAMES > 1) ? $clog2(PENDING_FRAMES) : 1;
    localparam int CW    = $clog2(RANGES_PER_FRAME + 1);
    localparam int DEPTH = PENDING_FRAMES * RANGES_PER_FRAME;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_LOOK = 3'd1;
    localparam logic [2:0] S_SCAN = 3'd2;
    localparam logic [2:0] S_DEC  = 3'd3;
    localparam logic [2:0] S_DONE = 3'd4;

    logic [2:0]     r_state;
    frt_pkg::t_item r_cmd;

    logic           r_ev   [PENDING_FRAMES];
    logic [15:0]    r_eid  [PENDING_FRAMES];
    logic [15:0]    r_elen [PENDING_FRAMES];
    logic [15:0]    r_ecov [PENDING_FRAMES];
    logic [CW-1:0]  r_ecnt [PENDING_FRAMES];

    logic [31:0]    r_mem [DEPTH];
    logic [31:0]    r_rdata;

    logic [EW-1:0]  r_e;
    logic [15:0]    r_flen, r_cov;
    logic [CW-1:0]  r_cnt, r_k;
    logic           r_dv, r_clash;
    logic [2:0]     r_st;
    logic [15:0]    r_sz;

    logic           hit, has_free;
    logic [EW-1:0]  hit_idx, free_idx, sel;
    logic [15:0]    sel_len, sel_cov, new_cov;
    logic [CW-1:0]  sel_cnt;
    logic           issue, rng_clash;
    logic [AW-1:0]  rd_addr, wr_addr;
    logic [16:0]    s_end;

    // Lowest-index match and lowest free slot
    always_comb begin
        hit      = 1'b0;
        has_free = 1'b0;
        hit_idx  = '0;
        free_idx = '0;
        for (int i = PENDING_FRAMES - 1; i >= 0; i--) begin
            if (r_ev[i] && r_eid[i] == r_cmd.frame_id) begin
                hit     = 1'b1;
                hit_idx = EW'(i);
            end
            if (!r_ev[i]) begin
                has_free = 1'b1;
                free_idx = EW'(i);
            end
        end
        sel     = hit ? hit_idx : free_idx;
        sel_len = hit ? r_elen[hit_idx] : r_cmd.frame_total_size;
        sel_cov = hit ? r_ecov[hit_idx] : 16'd0;
        sel_cnt = hit ? r_ecnt[hit_idx] : '0;
    end

    assign issue     = (r_k < r_cnt);
    assign rd_addr   = AW'(32'(r_e) * 32'(RANGES_PER_FRAME) + 32'(r_k));
    assign wr_addr   = AW'(32'(r_e) * 32'(RANGES_PER_FRAME) + 32'(r_cnt));
    assign s_end     = {1'b0, r_rdata[31:16]} + {1'b0, r_rdata[15:0]};
    assign rng_clash = ({1'b0, r_cmd.frag_start} < s_end) &&
                       (r_cmd.frag_end > {1'b0, r_rdata[31:16]});
    assign new_cov   = r_cov + r_cmd.frag_length;
    assign o_q_pop   = (r_state == S_IDLE) && i_q_valid;

    // Range memory: start in the upper half, length in the lower
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[rd_addr];
        if (r_state == S_DEC && !r_clash && r_cnt < CW'(RANGES_PER_FRAME)) begin
            r_mem[wr_addr] <= {r_cmd.frag_start, r_cmd.frag_length};
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_q_pop) r_cmd <= i_q_item;
        case (r_state)
            S_LOOK: begin
                if (!hit && r_cmd.frame_total_size != 16'd0 && has_free) begin
                    r_eid[free_idx]  <= r_cmd.frame_id;
                    r_elen[free_idx] <= r_cmd.frame_total_size;
                    r_ecov[free_idx] <= 16'd0;
                    r_ecnt[free_idx] <= '0;
                end
                r_e     <= sel;
                r_flen  <= sel_len;
                r_cov   <= sel_cov;
                r_cnt   <= sel_cnt;
                r_k     <= '0;
                r_clash <= 1'b0;
                r_dv    <= 1'b0;
            end
            S_SCAN: begin
                r_dv <= issue;
                if (issue) r_k <= r_k + 1'b1;
                if (r_dv && rng_clash) r_clash <= 1'b1;
            end
            S_DEC: begin
                if (!r_clash && r_cnt < CW'(RANGES_PER_FRAME)) begin
                    r_ecnt[r_e] <= r_cnt + 1'b1;
                    r_ecov[r_e] <= new_cov;
                end
            end
            default: ;
        endcase
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            o_out_valid <= 1'b0;
            for (int i = 0; i < PENDING_FRAMES; i++) r_ev[i] <= 1'b0;
        end else begin
            if (o_out_valid && !i_out_stall && r_state != S_DONE) o_out_valid <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (i_q_valid) r_state <= S_LOOK;
                end
                S_LOOK: begin
                    if (!hit && r_cmd.frame_total_size == 16'd0) begin
                        r_st    <= frt_pkg::ST_ZERO_SIZE;
                        r_sz    <= 16'd0;
                        r_state <= S_DONE;
                    end else if (!hit && !has_free) begin
                        r_st    <= frt_pkg::ST_TABLE_FULL;
                        r_sz    <= 16'd0;
                        r_state <= S_DONE;
                    end else begin
                        r_sz <= sel_len;
                        if (!hit) r_ev[free_idx] <= 1'b1;
                        if (r_cmd.len_zero || r_cmd.frag_end > {1'b0, sel_len}) begin
                            r_st    <= frt_pkg::ST_BAD_RANGE;
                            r_state <= S_DONE;
                        end else begin
                            r_state <= S_SCAN;
                        end
                    end
                end
                S_SCAN: begin
                    if (!issue && !r_dv) r_state <= S_DEC;
                end
                S_DEC: begin
                    r_state <= S_DONE;
                    if (r_clash) begin
                        r_st <= frt_pkg::ST_OVERLAP;
                    end else if (r_cnt >= CW'(RANGES_PER_FRAME)) begin
                        r_st <= frt_pkg::ST_RANGES_FULL;
                    end else if (new_cov == r_flen) begin
                        r_st       <= frt_pkg::ST_COMPLETE;
                        r_ev[r_e]  <= 1'b0;
                    end else begin
                        r_st <= frt_pkg::ST_ACCEPTED;
                    end
                end
                S_DONE: begin
                    if (!o_out_valid || !i_out_stall) begin
                        o_out_valid       <= 1'b1;
                        o_status          <= r_st;
                        o_done_frame_id   <= r_cmd.frame_id;
                        o_done_frame_size <= r_sz;
                        r_state           <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

[hw/rtl/frt_checker.sv]
// Port-level checks for the fragment reassembly tracker, bound to the top level.
`default_nettype none
module frt_port_checks (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_out_valid,
    input wire logic        i_out_stall,
    input wire logic [2:0]  i_status,
    input wire logic [15:0] i_done_frame_size
);
    a_reset_clears: assert property (@(posedge i_clk) !i_rst_n |=> !i_out_valid)
        else $error("result valid after reset");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_stall |=> i_out_valid && $stable(i_status))
        else $error("stalled result changed");

    a_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> i_status != 3'd7)
        else $error("unknown status code");

    a_no_entry_size: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_status == frt_pkg::ST_TABLE_FULL ||
                        i_status == frt_pkg::ST_ZERO_SIZE) |-> i_done_frame_size == 16'd0)
        else $error("size reported without an entry");
endmodule

bind fragment_reassembly_tracker_top frt_port_checks u_frt_checker (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .i_out_valid       (o_out_valid),
    .i_out_stall       (i_out_stall),
    .i_status          (o_status),
    .i_done_frame_size (o_done_frame_size)
);
`default_nettype wire
